[rtl/assert_macros.svh]
// Assertion macros shared by the grid occupancy map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GOM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define GOM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/gom_pkg.sv]
// Shared types and constants for the grid occupancy map.
package gom_pkg;

	localparam int unsigned DEF_MAX_ROWS    = 64;
	localparam int unsigned DEF_MAX_COLUMNS = 64;
	localparam int unsigned DEF_MAX_UNITS   = 256;
	localparam int unsigned DEF_MAX_RADIUS  = 3;

	localparam int unsigned ID_W    = 8;
	localparam int unsigned COORD_W = 6;
	localparam int unsigned RAD_W   = 2;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned CRD_W   = 10;

	localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

	typedef enum logic [1:0] {
		CMD_PLACE  = 2'd0,
		CMD_MOVE   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_SCAN   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_MOVE2,
		ST_RESP,
		ST_SCAN,
		ST_SCAN_END
	} state_t;

	typedef struct packed {
		logic start;
		logic advance;
	} scan_ctl_t;

	typedef struct packed {
		logic req;
		logic done;
	} scan_stat_t;

endpackage

[rtl/grid_occupancy_map_unit.sv]
// Grid occupancy map top level: command sequencer, cell and unit memories.
//
// channel  dir  handshake             payload
// in       in   in_valid / in_ready   cmd, unit_id, x_coord, y_coord, radius
// out      out  out_valid / out_ready success, has_neighbour, neighbour_id, last
// cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// After reset a clearing pass writes max(MAX_ROWS*MAX_COLUMNS, units) entries, one per
// cycle (4096 at default size); no command is taken until it ends, config writes are.
// Place and remove do a unit and cell lookup, then write back; move writes back twice,
// clearing the old cell, then filling the new one. Scan reads one cell a cycle, while
// the output is not stalled, from the single cell memory read port.
// A held output register stalls the scan walk when a further hit needs it; the next
// command may be taken while the final result of the previous one waits in it.
`include "assert_macros.svh"

module grid_occupancy_map_unit #(
	parameter int unsigned MAX_ROWS    = gom_pkg::DEF_MAX_ROWS,
	parameter int unsigned MAX_COLUMNS = gom_pkg::DEF_MAX_COLUMNS,
	parameter int unsigned MAX_UNITS   = gom_pkg::DEF_MAX_UNITS,
	parameter int unsigned MAX_RADIUS  = gom_pkg::DEF_MAX_RADIUS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gom_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gom_pkg::CNT_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       cmd,
	input  logic [gom_pkg::ID_W-1:0]         unit_id,
	input  logic [gom_pkg::COORD_W-1:0]      x_coord,
	input  logic [gom_pkg::COORD_W-1:0]      y_coord,
	input  logic [gom_pkg::RAD_W-1:0]        radius,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             success,
	output logic                             has_neighbour,
	output logic [gom_pkg::ID_W-1:0]         neighbour_id,
	output logic                             last
);

	localparam int unsigned ID_W       = gom_pkg::ID_W;
	localparam int unsigned CRD_W      = gom_pkg::CRD_W;
	localparam int unsigned XW         = $clog2(MAX_ROWS);
	localparam int unsigned YW         = $clog2(MAX_COLUMNS);
	localparam int unsigned CELLS      = MAX_ROWS * MAX_COLUMNS;
	localparam int unsigned AW         = $clog2(CELLS);
	localparam int unsigned ID_SPAN    = 1 << ID_W;
	localparam int unsigned UNIT_DEPTH = (MAX_UNITS < ID_SPAN) ? MAX_UNITS : ID_SPAN;
	localparam int unsigned UIW        = $clog2(UNIT_DEPTH);
	localparam int unsigned UW         = 1 + XW + YW;
	localparam int unsigned CLR_N      = (CELLS > UNIT_DEPTH) ? CELLS : UNIT_DEPTH;
	localparam int unsigned CLR_W      = $clog2(CLR_N);

	gom_pkg::state_t              state_q, state_d;
	gom_pkg::cmd_t                cmd_q;
	logic [ID_W-1:0]              id_q;
	logic [gom_pkg::COORD_W-1:0]  x_q, y_q;
	logic [gom_pkg::RAD_W-1:0]    radius_q;
	logic                         ok_q, ok_d;
	logic [CLR_W-1:0]             clr_q;
	logic [gom_pkg::CNT_W-1:0]    row_count_q, column_count_q;
	logic [CRD_W-1:0]             eff_rows, eff_cols;

	logic                         cell_we, cell_re;
	logic [AW-1:0]                cell_waddr, cell_raddr;
	logic [ID_W-1:0]              cell_wdata, cell_rdata;
	logic                         unit_we, unit_re;
	logic [UIW-1:0]               unit_waddr, unit_raddr;
	logic [UW-1:0]                unit_wdata, unit_rdata;

	logic                         u_present;
	logic [XW-1:0]                u_px;
	logic [YW-1:0]                u_py;
	logic [AW-1:0]                tgt_in_addr, tgt_addr, old_addr;
	logic                         id_ok, known, tgt_ok, vacant, place_ok, move_ok;

	gom_pkg::scan_ctl_t           scan_ctl;
	gom_pkg::scan_stat_t          scan_stat;
	logic [AW-1:0]                scan_addr;

	logic                         rd_v_s1;
	logic                         pend_valid_q;
	logic [ID_W-1:0]              pend_id_q;
	logic                         hit, stall, out_free;

	logic                         out_valid_q, success_q, has_neighbour_q, last_q;
	logic [ID_W-1:0]              neighbour_id_q;
	logic                         out_load, out_success_d, out_hit_d, out_last_d;
	logic [ID_W-1:0]              out_id_d;

	// memories
	gom_ram #(.WIDTH(ID_W), .DEPTH(CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (cell_re),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	gom_ram #(.WIDTH(UW), .DEPTH(UNIT_DEPTH)) u_unit_ram (
		.clk   (clk),
		.we    (unit_we),
		.waddr (unit_waddr),
		.wdata (unit_wdata),
		.re    (unit_re),
		.raddr (unit_raddr),
		.rdata (unit_rdata)
	);

	gom_scan #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_RADIUS  (MAX_RADIUS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.radius   (radius_q),
		.px       (u_px),
		.py       (u_py),
		.eff_rows (eff_rows),
		.eff_cols (eff_cols),
		.stat     (scan_stat),
		.addr     (scan_addr)
	);

	// decode
	assign eff_rows = (CRD_W'(row_count_q) > CRD_W'(MAX_ROWS)) ? CRD_W'(MAX_ROWS)
	                                                           : CRD_W'(row_count_q);
	assign eff_cols = (CRD_W'(column_count_q) > CRD_W'(MAX_COLUMNS)) ? CRD_W'(MAX_COLUMNS)
	                                                                 : CRD_W'(column_count_q);

	assign u_present = unit_rdata[UW-1];
	assign u_px      = unit_rdata[UW-2 -: XW];
	assign u_py      = unit_rdata[YW-1:0];

	assign tgt_in_addr = AW'(32'(x_coord) * MAX_COLUMNS + 32'(y_coord));
	assign tgt_addr    = AW'(32'(x_q) * MAX_COLUMNS + 32'(y_q));
	assign old_addr    = AW'(32'(u_px) * MAX_COLUMNS + 32'(u_py));

	assign id_ok    = 32'(id_q) < MAX_UNITS;
	assign known    = id_ok && u_present;
	assign tgt_ok   = (CRD_W'(x_q) < eff_rows) && (CRD_W'(y_q) < eff_cols);
	assign vacant   = tgt_ok && (cell_rdata == '0);
	assign place_ok = (id_q != '0) && id_ok && !u_present && vacant;
	assign move_ok  = vacant && known;

	assign out_free = !out_valid_q || out_ready;
	assign hit      = rd_v_s1 && (cell_rdata != '0);
	assign stall    = hit && pend_valid_q && !out_free;

	always_comb begin
		case (cmd_q)
			gom_pkg::CMD_PLACE: ok_d = place_ok;
			gom_pkg::CMD_MOVE:  ok_d = move_ok;
			default:            ok_d = known;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gom_pkg::ST_CLEAR: begin
				if (clr_q == CLR_W'(CLR_N - 1)) state_d = gom_pkg::ST_IDLE;
			end
			gom_pkg::ST_IDLE: begin
				if (in_valid) state_d = gom_pkg::ST_LOOKUP;
			end
			gom_pkg::ST_LOOKUP: begin
				if (cmd_q == gom_pkg::CMD_SCAN && known) state_d = gom_pkg::ST_SCAN;
				else if (cmd_q == gom_pkg::CMD_MOVE && move_ok) state_d = gom_pkg::ST_MOVE2;
				else state_d = gom_pkg::ST_RESP;
			end
			gom_pkg::ST_MOVE2: state_d = gom_pkg::ST_RESP;
			gom_pkg::ST_RESP: begin
				if (out_free) state_d = gom_pkg::ST_IDLE;
			end
			gom_pkg::ST_SCAN: begin
				if (scan_stat.done && !rd_v_s1) state_d = gom_pkg::ST_SCAN_END;
			end
			gom_pkg::ST_SCAN_END: begin
				if (out_free) state_d = gom_pkg::ST_IDLE;
			end
			default: state_d = gom_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready         = 1'b0;
		cell_we          = 1'b0;
		cell_waddr       = tgt_addr;
		cell_wdata       = '0;
		cell_re          = 1'b0;
		cell_raddr       = scan_addr;
		unit_we          = 1'b0;
		unit_waddr       = UIW'(id_q);
		unit_wdata       = {1'b1, XW'(x_q), YW'(y_q)};
		unit_re          = 1'b0;
		unit_raddr       = UIW'(unit_id);
		scan_ctl.start   = 1'b0;
		scan_ctl.advance = 1'b0;
		out_load         = 1'b0;
		out_success_d    = 1'b1;
		out_hit_d        = 1'b0;
		out_id_d         = '0;
		out_last_d       = 1'b1;
		case (state_q)
			gom_pkg::ST_CLEAR: begin
				cell_we    = 32'(clr_q) < CELLS;
				cell_waddr = clr_q[AW-1:0];
				unit_we    = 32'(clr_q) < UNIT_DEPTH;
				unit_waddr = clr_q[UIW-1:0];
				unit_wdata = '0;
			end
			gom_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cell_re    = in_valid;
				cell_raddr = tgt_in_addr;
				unit_re    = in_valid;
			end
			gom_pkg::ST_LOOKUP: begin
				case (cmd_q)
					gom_pkg::CMD_PLACE: begin
						cell_we    = place_ok;
						cell_wdata = id_q;
						unit_we    = place_ok;
					end
					gom_pkg::CMD_MOVE: begin
						cell_we    = move_ok;
						cell_waddr = old_addr;
						unit_we    = move_ok;
					end
					gom_pkg::CMD_REMOVE: begin
						cell_we    = known;
						cell_waddr = old_addr;
						unit_we    = known;
						unit_wdata = {1'b0, u_px, u_py};
					end
					default: begin
						scan_ctl.start = known;
					end
				endcase
			end
			gom_pkg::ST_MOVE2: begin
				cell_we    = 1'b1;
				cell_wdata = id_q;
			end
			gom_pkg::ST_RESP: begin
				out_load      = out_free;
				out_success_d = ok_q;
			end
			gom_pkg::ST_SCAN: begin
				scan_ctl.advance = !stall;
				cell_re          = scan_stat.req && !stall;
				out_load         = hit && pend_valid_q && out_free;
				out_hit_d        = 1'b1;
				out_id_d         = pend_id_q;
				out_last_d       = 1'b0;
			end
			gom_pkg::ST_SCAN_END: begin
				out_load  = out_free;
				out_hit_d = pend_valid_q;
				out_id_d  = pend_valid_q ? pend_id_q : '0;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= gom_pkg::ST_CLEAR;
			clr_q          <= '0;
			row_count_q    <= gom_pkg::COUNT_RESET;
			column_count_q <= gom_pkg::COUNT_RESET;
			out_valid_q    <= 1'b0;
			rd_v_s1        <= 1'b0;
			pend_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gom_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid) begin
				case (cfg_index)
					gom_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data;
					gom_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == gom_pkg::ST_SCAN) begin
				if (!stall) rd_v_s1 <= scan_stat.req;
			end else begin
				rd_v_s1 <= 1'b0;
			end
			if (state_q == gom_pkg::ST_SCAN && hit && !stall) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == gom_pkg::ST_SCAN_END && out_free) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q    <= gom_pkg::cmd_t'(cmd);
			id_q     <= unit_id;
			x_q      <= x_coord;
			y_q      <= y_coord;
			radius_q <= radius;
		end
		if (state_q == gom_pkg::ST_LOOKUP) begin
			ok_q <= ok_d;
		end
		if (state_q == gom_pkg::ST_SCAN && hit && !stall) begin
			pend_id_q <= cell_rdata;
		end
		if (out_load) begin
			success_q       <= out_success_d;
			has_neighbour_q <= out_hit_d;
			neighbour_id_q  <= out_id_d;
			last_q          <= out_last_d;
		end
	end

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign success       = success_q;
	assign has_neighbour = has_neighbour_q;
	assign neighbour_id  = neighbour_id_q;
	assign last          = last_q;

	`GOM_ASSERT_IMPL(a_rd_in_scan, rd_v_s1, state_q == gom_pkg::ST_SCAN, "scan read data outside scan")
	`GOM_ASSERT_IMPL(a_pend_in_scan, pend_valid_q, (state_q == gom_pkg::ST_SCAN) || (state_q == gom_pkg::ST_SCAN_END), "held hit outside scan")
	`GOM_ASSERT_NEXT(a_accept_clean, in_valid && in_ready, !pend_valid_q && !rd_v_s1 && (state_q == gom_pkg::ST_LOOKUP), "command taken with scan work in flight")

endmodule

[rtl/gom_ram.sv]
// Generic simple dual-port RAM with registered read.
module gom_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/gom_scan.sv]
// Neighborhood walker: steps the scan square and forms cell read addresses.
`include "assert_macros.svh"

module gom_scan #(
	parameter int unsigned MAX_ROWS    = gom_pkg::DEF_MAX_ROWS,
	parameter int unsigned MAX_COLUMNS = gom_pkg::DEF_MAX_COLUMNS,
	parameter int unsigned MAX_RADIUS  = gom_pkg::DEF_MAX_RADIUS
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  gom_pkg::scan_ctl_t                           ctl,
	input  logic [gom_pkg::RAD_W-1:0]                    radius,
	input  logic [$clog2(MAX_ROWS)-1:0]                  px,
	input  logic [$clog2(MAX_COLUMNS)-1:0]               py,
	input  logic [gom_pkg::CRD_W-1:0]                    eff_rows,
	input  logic [gom_pkg::CRD_W-1:0]                    eff_cols,
	output gom_pkg::scan_stat_t                          stat,
	output logic [$clog2(MAX_ROWS*MAX_COLUMNS)-1:0]      addr
);

	localparam int unsigned XW    = $clog2(MAX_ROWS);
	localparam int unsigned YW    = $clog2(MAX_COLUMNS);
	localparam int unsigned AW    = $clog2(MAX_ROWS * MAX_COLUMNS);
	localparam int unsigned CRD_W = gom_pkg::CRD_W;

	logic signed [2:0]                 dx_q, dy_q;
	logic [gom_pkg::RAD_W-1:0]         rad_q;
	logic                              done_q;
	logic [gom_pkg::RAD_W-1:0]         rad_in;
	logic signed [2:0]                 rad_s, rad_in_s;
	logic signed [CRD_W-1:0]           cx, cy;
	logic [CRD_W-1:0]                  cxu, cyu;
	logic                              x_ok, y_ok, self_cell;

	assign rad_in   = (radius > gom_pkg::RAD_W'(MAX_RADIUS)) ? gom_pkg::RAD_W'(MAX_RADIUS)
	                                                           : radius;
	assign rad_in_s = $signed({1'b0, rad_in});
	assign rad_s    = $signed({1'b0, rad_q});

	assign cx  = $signed({{(CRD_W - XW){1'b0}}, px}) + CRD_W'(dx_q);
	assign cy  = $signed({{(CRD_W - YW){1'b0}}, py}) + CRD_W'(dy_q);
	assign cxu = cx;
	assign cyu = cy;

	assign x_ok      = !cx[CRD_W-1] && (cxu < eff_rows);
	assign y_ok      = !cy[CRD_W-1] && (cyu < eff_cols);
	assign self_cell = (dx_q == 3'sd0) && (dy_q == 3'sd0);

	assign stat.req  = !done_q && x_ok && y_ok && !self_cell;
	assign stat.done = done_q;
	assign addr      = AW'(32'(cxu[CRD_W-3:0]) * MAX_COLUMNS + 32'(cyu[CRD_W-3:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b1;
		end else if (ctl.start) begin
			done_q <= 1'b0;
		end else if (ctl.advance && !done_q && dx_q == rad_s && dy_q == rad_s) begin
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rad_q <= rad_in;
			dx_q  <= -rad_in_s;
			dy_q  <= -rad_in_s;
		end else if (ctl.advance && !done_q) begin
			if (dy_q == rad_s) begin
				dy_q <= -rad_s;
				if (dx_q != rad_s) begin
					dx_q <= dx_q + 3'sd1;
				end
			end else begin
				dy_q <= dy_q + 3'sd1;
			end
		end
	end

	`GOM_ASSERT_NEXT(a_start_corner, ctl.start, (dx_q == dy_q) && !done_q, "scan did not start at the square corner")
	`GOM_ASSERT_IMPL(a_dx_range, !done_q, (dx_q >= -rad_s) && (dx_q <= rad_s), "scan row offset out of square")
	`GOM_ASSERT_NEXT(a_finish, ctl.advance && !done_q && dx_q == rad_s && dy_q == rad_s, done_q, "scan ran past the last cell")

endmodule

[tb/grid_occupancy_map_unit_tb.sv]
// Self-checking testbench for grid_occupancy_map_unit: directed and random map traffic.
`timescale 1ns / 100ps

module grid_occupancy_map_unit_tb;

	localparam int unsigned ID_W      = gom_pkg::ID_W;
	localparam int unsigned COORD_W   = gom_pkg::COORD_W;
	localparam int unsigned RAD_W     = gom_pkg::RAD_W;
	localparam int unsigned CNT_W     = gom_pkg::CNT_W;
	localparam int unsigned CFG_IDX_W = gom_pkg::CFG_IDX_W;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned SINK_HOLD     = 400;
	localparam int unsigned ID_POOL       = 48;
	localparam int unsigned GRID_CELLS    = gom_pkg::DEF_MAX_ROWS * gom_pkg::DEF_MAX_COLUMNS;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic            success;
		logic            has_neighbour;
		logic [ID_W-1:0] neighbour_id;
		logic            last;
	} map_reply_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CNT_W-1:0]     cfg_data      = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic [1:0]           cmd           = '0;
	logic [ID_W-1:0]      unit_id       = '0;
	logic [COORD_W-1:0]   x_coord       = '0;
	logic [COORD_W-1:0]   y_coord       = '0;
	logic [RAD_W-1:0]     radius        = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic                 success;
	logic                 has_neighbour;
	logic [ID_W-1:0]      neighbour_id;
	logic                 last;

	// shadow of the map
	logic [ID_W-1:0]    cell_shadow [0:GRID_CELLS-1];
	bit                 unit_on_map [0:gom_pkg::DEF_MAX_UNITS-1];
	logic [COORD_W-1:0] unit_x      [0:gom_pkg::DEF_MAX_UNITS-1];
	logic [COORD_W-1:0] unit_y      [0:gom_pkg::DEF_MAX_UNITS-1];
	logic [CNT_W-1:0]   rows_set = gom_pkg::COUNT_RESET;
	logic [CNT_W-1:0]   cols_set = gom_pkg::COUNT_RESET;

	map_reply_t  due_replies[$];
	int unsigned error_count      = 0;
	int unsigned commands_sent    = 0;
	int unsigned replies_checked  = 0;
	int unsigned reg_writes       = 0;
	int unsigned cycle_count      = 0;
	int unsigned sink_hold_cycles = 0;
	bit          gaps_on          = 1'b1;

	grid_occupancy_map_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.unit_id       (unit_id),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.radius        (radius),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.success       (success),
		.has_neighbour (has_neighbour),
		.neighbour_id  (neighbour_id),
		.last          (last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
				due_replies.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic int rows_eff();
		return (int'(rows_set) > int'(gom_pkg::DEF_MAX_ROWS)) ? int'(gom_pkg::DEF_MAX_ROWS)
		                                                       : int'(rows_set);
	endfunction

	function automatic int cols_eff();
		return (int'(cols_set) > int'(gom_pkg::DEF_MAX_COLUMNS))
			? int'(gom_pkg::DEF_MAX_COLUMNS) : int'(cols_set);
	endfunction

	function automatic bit in_grid(int x, int y);
		return x >= 0 && y >= 0 && x < rows_eff() && y < cols_eff();
	endfunction

	function automatic int cell_at(int x, int y);
		return x * int'(gom_pkg::DEF_MAX_COLUMNS) + y;
	endfunction

	function automatic void queue_reply(map_reply_t r);
		due_replies.insert(due_replies.size(), r);
	endfunction

	// Apply one accepted command to the shadow map and queue the replies it must produce.
	task automatic track_map_command(gom_pkg::cmd_t op, logic [ID_W-1:0] id,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [RAD_W-1:0] r);
		map_reply_t reply;
		map_reply_t held;
		bit         have_hit;
		int         px;
		int         py;
		int         rad;
		reply = '{success: 1'b0, has_neighbour: 1'b0, neighbour_id: '0, last: 1'b1};
		held = reply;
		have_hit = 1'b0;
		case (op)
			gom_pkg::CMD_PLACE: begin
				if (id != '0 && !unit_on_map[id] && in_grid(x, y)
						&& cell_shadow[cell_at(x, y)] == '0) begin
					cell_shadow[cell_at(x, y)] = id;
					unit_on_map[id] = 1'b1;
					unit_x[id] = x;
					unit_y[id] = y;
					reply.success = 1'b1;
				end
			end
			gom_pkg::CMD_MOVE: begin
				if (unit_on_map[id] && in_grid(x, y) && cell_shadow[cell_at(x, y)] == '0) begin
					cell_shadow[cell_at(unit_x[id], unit_y[id])] = '0;
					cell_shadow[cell_at(x, y)] = id;
					unit_x[id] = x;
					unit_y[id] = y;
					reply.success = 1'b1;
				end
			end
			gom_pkg::CMD_REMOVE: begin
				if (unit_on_map[id]) begin
					cell_shadow[cell_at(unit_x[id], unit_y[id])] = '0;
					unit_on_map[id] = 1'b0;
					reply.success = 1'b1;
				end
			end
			gom_pkg::CMD_SCAN: begin
				if (unit_on_map[id]) begin
					reply.success = 1'b1;
					rad = (int'(r) > int'(gom_pkg::DEF_MAX_RADIUS))
						? int'(gom_pkg::DEF_MAX_RADIUS) : int'(r);
					px = int'(unit_x[id]);
					py = int'(unit_y[id]);
					// x outer, y inner; a hit is queued once the next one shows it is not last
					for (int cx = px - rad; cx <= px + rad; cx++) begin
						for (int cy = py - rad; cy <= py + rad; cy++) begin
							if (in_grid(cx, cy) && !(cx == px && cy == py)
									&& cell_shadow[cell_at(cx, cy)] != '0) begin
								if (have_hit)
									queue_reply(held);
								held = '{success: 1'b1, has_neighbour: 1'b1,
									neighbour_id: cell_shadow[cell_at(cx, cy)], last: 1'b0};
								have_hit = 1'b1;
							end
						end
					end
					if (have_hit) begin
						held.last = 1'b1;
						reply = held;
					end
				end
			end
			default: begin
			end
		endcase
		queue_reply(reply);
		commands_sent++;
	endtask

	function automatic void check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// reply transfers happen at the next rising edge; values are stable at the falling edge
	always @(negedge clk) begin
		map_reply_t due;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (due_replies.size() == 0) begin
				$error("reply with none due: neighbour_id %0d, last %0d", neighbour_id, last);
				error_count++;
			end else begin
				due = due_replies.pop_front();
				check_field("success", ID_W'(due.success), ID_W'(success));
				check_field("has_neighbour", ID_W'(due.has_neighbour), ID_W'(has_neighbour));
				check_field("neighbour_id", due.neighbour_id, neighbour_id);
				check_field("last", ID_W'(due.last), ID_W'(last));
				replies_checked++;
			end
		end
	end

	initial begin : reply_sink
		int unsigned stall;
		@(posedge clk);
		forever begin
			if (sink_hold_cycles != 0) begin
				stall = sink_hold_cycles;
				sink_hold_cycles = 0;
			end else begin
				stall = gaps_on ? $urandom_range(0, 9) : 0;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (out_valid !== 1'b1);
			@(posedge clk);
		end
	end

	task automatic send_command(gom_pkg::cmd_t op, logic [ID_W-1:0] id, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [RAD_W-1:0] r);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		unit_id  <= id;
		x_coord  <= x;
		y_coord  <= y;
		radius   <= r;
		do @(negedge clk); while (in_ready !== 1'b1);
		@(posedge clk);
		track_map_command(op, id, x, y, r);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (due_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// more: keep valid up because another write follows at once
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data, bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		if (!more)
			cfg_valid <= 1'b0;
		if (idx == gom_pkg::REG_ROW_COUNT)
			rows_set = data;
		else if (idx == gom_pkg::REG_COLUMN_COUNT)
			cols_set = data;
		reg_writes++;
	endtask

	task automatic configure(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
		wait_idle();
		write_reg(gom_pkg::REG_ROW_COUNT, rows, 1'b1);
		write_reg(gom_pkg::REG_COLUMN_COUNT, cols, 1'b0);
	endtask

	function automatic logic [ID_W-1:0] pick_unit_on_map();
		logic [ID_W-1:0] id;
		id = ID_W'($urandom_range(1, ID_POOL));
		for (int k = 0; k < 24 && !unit_on_map[id]; k++)
			id = ID_W'($urandom_range(1, ID_POOL));
		return id;
	endfunction

	// mostly known ids inside a 10x10 window at (bx, by), some noise over the full field
	task automatic send_random_command(int bx, int by);
		gom_pkg::cmd_t      op;
		logic [ID_W-1:0]    id;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		int unsigned        roll;
		roll = $urandom_range(0, 9);
		if (roll < 3)
			op = gom_pkg::CMD_PLACE;
		else if (roll < 6)
			op = gom_pkg::CMD_MOVE;
		else if (roll < 7)
			op = gom_pkg::CMD_REMOVE;
		else
			op = gom_pkg::CMD_SCAN;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			id = ID_W'($urandom);
		else if (roll < 7)
			id = '0;
		else if (op != gom_pkg::CMD_PLACE && roll < 80)
			id = pick_unit_on_map();
		else
			id = ID_W'($urandom_range(1, ID_POOL));
		if ($urandom_range(0, 9) == 0) begin
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
		end else begin
			x = COORD_W'(bx + int'($urandom_range(0, 9)));
			y = COORD_W'(by + int'($urandom_range(0, 9)));
		end
		send_command(op, id, x, y, RAD_W'($urandom));
	endtask

	task automatic random_phase(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols, int items);
		int bx;
		int by;
		configure(rows, cols);
		// window reaches the upper edge of the grid and straddles it on smaller grids
		bx = (int'(rows) > 62) ? 54 : ((int'(rows) > 8) ? int'(rows) - 8 : 0);
		by = (int'(cols) > 62) ? 54 : ((int'(cols) > 8) ? int'(cols) - 8 : 0);
		for (int n = 0; n < items; n++) begin
			if (n % 40 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			send_random_command(bx, by);
		end
	endtask

	task automatic test_place_move_remove();
		send_command(gom_pkg::CMD_PLACE, 8'd0, 6'd5, 6'd5, 2'd0);
		send_command(gom_pkg::CMD_PLACE, 8'd1, 6'd0, 6'd0, 2'd0);
		send_command(gom_pkg::CMD_PLACE, 8'd255, 6'd63, 6'd63, 2'd3);
		send_command(gom_pkg::CMD_PLACE, 8'd1, 6'd10, 6'd10, 2'd0);
		send_command(gom_pkg::CMD_PLACE, 8'd3, 6'd0, 6'd0, 2'd0);
		send_command(gom_pkg::CMD_MOVE, 8'd1, 6'd0, 6'd0, 2'd0);
		send_command(gom_pkg::CMD_MOVE, 8'd4, 6'd1, 6'd1, 2'd0);
		send_command(gom_pkg::CMD_MOVE, 8'd1, 6'd1, 6'd1, 2'd0);
		send_command(gom_pkg::CMD_MOVE, 8'd1, 6'd63, 6'd63, 2'd0);
		send_command(gom_pkg::CMD_REMOVE, 8'd0, 6'd0, 6'd0, 2'd0);
		send_command(gom_pkg::CMD_REMOVE, 8'd255, 6'd0, 6'd0, 2'd0);
		send_command(gom_pkg::CMD_REMOVE, 8'd255, 6'd0, 6'd0, 2'd0);
	endtask

	task automatic test_scan();
		send_command(gom_pkg::CMD_PLACE, 8'd10, 6'd20, 6'd20, 2'd0);
		send_command(gom_pkg::CMD_PLACE, 8'd11, 6'd17, 6'd17, 2'd0);
		send_command(gom_pkg::CMD_PLACE, 8'd12, 6'd23, 6'd23, 2'd0);
		send_command(gom_pkg::CMD_PLACE, 8'd13, 6'd20, 6'd21, 2'd0);
		send_command(gom_pkg::CMD_SCAN, 8'd10, 6'd0, 6'd0, 2'd3);
		send_command(gom_pkg::CMD_SCAN, 8'd10, 6'd0, 6'd0, 2'd0);
		send_command(gom_pkg::CMD_SCAN, 8'd10, 6'd0, 6'd0, 2'd1);
		send_command(gom_pkg::CMD_SCAN, 8'd9, 6'd0, 6'd0, 2'd2);
		send_command(gom_pkg::CMD_PLACE, 8'd5, 6'd0, 6'd2, 2'd0);
		send_command(gom_pkg::CMD_SCAN, 8'd1, 6'd63, 6'd63, 2'd3);
	endtask

	task automatic test_shrunk_grid();
		configure(7'd1, 7'd1);
		send_command(gom_pkg::CMD_PLACE, 8'd20, 6'd0, 6'd0, 2'd0);
		send_command(gom_pkg::CMD_PLACE, 8'd21, 6'd1, 6'd0, 2'd0);
		send_command(gom_pkg::CMD_SCAN, 8'd20, 6'd0, 6'd0, 2'd3);
		send_command(gom_pkg::CMD_SCAN, 8'd10, 6'd0, 6'd0, 2'd3);
		send_command(gom_pkg::CMD_MOVE, 8'd11, 6'd0, 6'd1, 2'd0);
		send_command(gom_pkg::CMD_REMOVE, 8'd10, 6'd0, 6'd0, 2'd0);
		configure(7'd0, 7'd64);
		send_command(gom_pkg::CMD_PLACE, 8'd22, 6'd0, 6'd0, 2'd0);
		send_command(gom_pkg::CMD_SCAN, 8'd20, 6'd0, 6'd0, 2'd1);
		configure(7'd127, 7'd100);
		send_command(gom_pkg::CMD_PLACE, 8'd22, 6'd63, 6'd63, 2'd0);
		send_command(gom_pkg::CMD_SCAN, 8'd22, 6'd0, 6'd0, 2'd3);
	endtask

	task automatic test_spare_registers();
		wait_idle();
		write_reg(REG_SPARE_A, 7'd0, 1'b1);
		write_reg(REG_SPARE_B, 7'd0, 1'b0);
		send_command(gom_pkg::CMD_PLACE, 8'd23, 6'd40, 6'd40, 2'd0);
		send_command(gom_pkg::CMD_SCAN, 8'd23, 6'd0, 6'd0, 2'd3);
	endtask

	task automatic test_back_pressure();
		configure(7'd8, 7'd8);
		gaps_on = 1'b0;
		sink_hold_cycles = SINK_HOLD;
		for (int n = 0; n < 30; n++)
			send_random_command(0, 0);
		wait_idle();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		random_phase(7'd8, 7'd8, 70);
		random_phase(7'd16, 7'd12, 60);
		random_phase(7'd64, 7'd64, 70);
		random_phase(7'd3, 7'd64, 60);
		random_phase(7'd64, 7'd5, 60);
		random_phase(7'd127, 7'd127, 70);
	endtask

	initial begin
		foreach (cell_shadow[i])
			cell_shadow[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_place_move_remove();
		test_scan();
		test_shrunk_grid();
		test_spare_registers();
		test_back_pressure();
		test_random_traffic();
		wait_idle();
		$display("%0d commands, %0d replies checked, %0d register writes", commands_sent,
			replies_checked, reg_writes);
		$display("grid sizes 0 to 127 per axis, %0d-cycle output stall with input backed up",
			SINK_HOLD);
		if (error_count == 0 && due_replies.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
